### sv/fbfl_pkg.sv
// Shared types and constants for the fixed block free list allocator.
// Used by fbfl_ctrl, fbfl_dp and the top level; depends on nothing.
package fbfl_pkg;

  // Default pool depth handed to the top-level parameter.
  localparam int NUM_BLOCKS_DEF = 256;

  // Fixed field widths of the ports.
  localparam int MODE_W      = 2;
  localparam int INDEX_W     = 8;
  localparam int OFFSET_W    = 24;
  localparam int USED_W      = 9;
  localparam int POOL_W      = 9;
  localparam int BYTES_W     = 17;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // Register reset values and limits.
  localparam logic [POOL_W-1:0]  POOL_BLOCKS_RST = 9'd256;
  localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = 17'd64;
  localparam logic [BYTES_W-1:0] BLOCK_BYTES_MIN = 17'd8;
  localparam logic [USED_W-1:0]  USED_MAX        = 9'd511;

  // Register index, taken from byte address bit 2.
  localparam logic REG_POOL_BLOCKS = 1'b0;
  localparam logic REG_BLOCK_BYTES = 1'b1;

  // Command codes on the input word.
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REBUILD = 2'd2;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_IGNORED   = 2'd2,
    ST_REBUILT   = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    alloc_rd;     // read the link of the head block
    logic    alloc_pop;    // head takes the link that was read
    logic    free_push;    // link the returned block in front of the head
    logic    walk_start;   // begin a rebuild walk
    logic    walk_step;    // write one chain entry
    logic    walk_finish;  // last entry written: reset head and count
    logic    emit;         // present a result word
    status_t status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic head_null;
    logic free_ok;
    logic walk_last;
  } sts_t;

endpackage

### sv/fbfl_ctrl.sv
// Controller state machine of the free list allocator.
// Depends on fbfl_pkg; drives fbfl_dp through cmd_t and reads sts_t.
module fbfl_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [fbfl_pkg::MODE_W-1:0]  in_mode,
  input  fbfl_pkg::sts_t               sts,
  output fbfl_pkg::cmd_t               cmd,
  output logic                         busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_WALK
  } state_t;

  state_t state_r, state_nxt;
  logic   report_r, report_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt  = state_r;
    report_nxt = report_r;
    cmd        = '0;
    cmd.status = fbfl_pkg::ST_IGNORED;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_mode)
            fbfl_pkg::MODE_ALLOC: begin
              if (sts.head_null) begin
                cmd.emit   = 1'b1;
                cmd.status = fbfl_pkg::ST_EXHAUSTED;
              end else begin
                cmd.alloc_rd = 1'b1;
                state_nxt    = S_POP;
              end
            end
            fbfl_pkg::MODE_FREE: begin
              cmd.emit = 1'b1;
              if (sts.free_ok) begin
                cmd.free_push = 1'b1;
                cmd.status    = fbfl_pkg::ST_DONE;
              end
            end
            fbfl_pkg::MODE_REBUILD: begin
              cmd.walk_start = 1'b1;
              report_nxt     = 1'b1;
              state_nxt      = S_WALK;
            end
            default: begin
              cmd.emit = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        cmd.alloc_pop = 1'b1;
        cmd.emit      = 1'b1;
        cmd.status    = fbfl_pkg::ST_DONE;
        state_nxt     = S_IDLE;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_last) begin
          cmd.walk_finish = 1'b1;
          cmd.emit        = report_r;
          cmd.status      = fbfl_pkg::ST_REBUILT;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The walk that follows reset builds the chain silently.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_WALK;
      report_r <= 1'b0;
      busy_r   <= 1'b1;
    end else begin
      state_r  <= state_nxt;
      report_r <= report_nxt;
      busy_r   <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

### sv/fbfl_dp.sv
// Datapath of the free list allocator: link memory, head, use count,
// rebuild walker, offset multiplier and result registers. Depends on fbfl_pkg.
module fbfl_dp #(
  parameter int NUM_BLOCKS = fbfl_pkg::NUM_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fbfl_pkg::cmd_t                 cmd,
  output fbfl_pkg::sts_t                 sts,
  input  logic [fbfl_pkg::INDEX_W-1:0]   in_free_index,
  input  logic                           in_free_is_null,
  input  logic [fbfl_pkg::POOL_W-1:0]    pool_blocks,
  input  logic [fbfl_pkg::BYTES_W-1:0]   block_bytes,
  output logic                           out_valid,
  output logic [1:0]                     out_status,
  output logic [fbfl_pkg::INDEX_W-1:0]   out_block_index,
  output logic [fbfl_pkg::OFFSET_W-1:0]  out_byte_offset,
  output logic [fbfl_pkg::USED_W-1:0]    out_used_count
);

  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_W  = (LINK_W > fbfl_pkg::POOL_W) ? LINK_W : fbfl_pkg::POOL_W;
  localparam int PROD_W = (LINK_W + fbfl_pkg::BYTES_W > fbfl_pkg::OFFSET_W) ?
                          (LINK_W + fbfl_pkg::BYTES_W) : fbfl_pkg::OFFSET_W;
  localparam int RST_COUNT = (NUM_BLOCKS < int'(fbfl_pkg::POOL_BLOCKS_RST)) ?
                             NUM_BLOCKS : int'(fbfl_pkg::POOL_BLOCKS_RST);
  localparam logic [IDX_W-1:0]  RST_LAST  = IDX_W'(RST_COUNT - 1);
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_BLOCKS);

  logic [LINK_W-1:0] link_mem [NUM_BLOCKS];

  logic [LINK_W-1:0]               head_r, head_nxt;
  logic [fbfl_pkg::USED_W-1:0]     used_r, used_nxt;
  logic [IDX_W-1:0]                walk_cnt_r, walk_cnt_nxt;
  logic [IDX_W-1:0]                walk_last_r, walk_last_nxt;
  logic [LINK_W-1:0]               rd_data_r;

  logic                            out_valid_r;
  logic [1:0]                      out_status_r;
  logic [fbfl_pkg::INDEX_W-1:0]    out_index_r, out_index_nxt;
  logic [fbfl_pkg::OFFSET_W-1:0]   out_offset_r, out_offset_nxt;
  logic [fbfl_pkg::USED_W-1:0]     out_used_r;

  logic                            wr_en;
  logic [IDX_W-1:0]                wr_addr;
  logic [LINK_W-1:0]               wr_data;
  logic [CMP_W-1:0]                pool_ext;
  logic [CMP_W-1:0]                last_ext;
  logic [fbfl_pkg::BYTES_W-1:0]    bytes_eff;
  logic [LINK_W-1:0]               mul_idx;
  logic [PROD_W-1:0]               product;

  // Clamp the pool count to one through NUM_BLOCKS and take the last index.
  always_comb begin
    pool_ext = CMP_W'(pool_blocks);
    if (pool_ext == '0) begin
      last_ext = '0;
    end else if (pool_ext > CMP_W'(NUM_BLOCKS)) begin
      last_ext = CMP_W'(NUM_BLOCKS - 1);
    end else begin
      last_ext = pool_ext - CMP_W'(1);
    end
  end

  assign sts.head_null = (head_r >= LINK_NULL);
  assign sts.free_ok   = !in_free_is_null &&
                         (CMP_W'(in_free_index) < CMP_W'(NUM_BLOCKS));
  assign sts.walk_last = (walk_cnt_r == walk_last_r);

  assign bytes_eff = (block_bytes < fbfl_pkg::BLOCK_BYTES_MIN) ?
                     fbfl_pkg::BLOCK_BYTES_MIN : block_bytes;
  assign mul_idx   = cmd.alloc_pop ? head_r : LINK_W'(in_free_index);
  assign product   = PROD_W'(mul_idx) * PROD_W'(bytes_eff);

  // One write port: a pushed block takes the old head, a walk writes the chain.
  always_comb begin
    wr_en   = cmd.free_push || cmd.walk_step;
    wr_addr = cmd.free_push ? IDX_W'(in_free_index) : walk_cnt_r;
    if (cmd.free_push) begin
      wr_data = head_r;
    end else if (sts.walk_last) begin
      wr_data = LINK_NULL;
    end else begin
      wr_data = LINK_W'(walk_cnt_r) + LINK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_rd) begin
      rd_data_r <= link_mem[head_r[IDX_W-1:0]];
    end
  end

  always_comb begin
    head_nxt      = head_r;
    used_nxt      = used_r;
    walk_cnt_nxt  = walk_cnt_r;
    walk_last_nxt = walk_last_r;
    out_index_nxt  = '0;
    out_offset_nxt = '0;
    if (cmd.alloc_pop) begin
      head_nxt       = rd_data_r;
      used_nxt       = (used_r < fbfl_pkg::USED_MAX) ? used_r + 1'b1 : used_r;
      out_index_nxt  = fbfl_pkg::INDEX_W'(head_r);
      out_offset_nxt = product[fbfl_pkg::OFFSET_W-1:0];
    end
    if (cmd.free_push) begin
      head_nxt       = LINK_W'(in_free_index);
      used_nxt       = (used_r != '0) ? used_r - 1'b1 : used_r;
      out_index_nxt  = in_free_index;
      out_offset_nxt = product[fbfl_pkg::OFFSET_W-1:0];
    end
    if (cmd.walk_start) begin
      walk_cnt_nxt  = '0;
      walk_last_nxt = IDX_W'(last_ext);
    end
    if (cmd.walk_step && !sts.walk_last) begin
      walk_cnt_nxt = walk_cnt_r + 1'b1;
    end
    if (cmd.walk_finish) begin
      head_nxt = '0;
      used_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      used_r      <= '0;
      walk_cnt_r  <= '0;
      walk_last_r <= RST_LAST;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      used_r      <= used_nxt;
      walk_cnt_r  <= walk_cnt_nxt;
      walk_last_r <= walk_last_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.status;
      out_index_r  <= out_index_nxt;
      out_offset_r <= out_offset_nxt;
      out_used_r   <= used_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_index = out_index_r;
  assign out_byte_offset = out_offset_r;
  assign out_used_count  = out_used_r;

`ifndef SYNTHESIS
  a_pop_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_pop |-> $past(cmd.alloc_rd))
    else $error("pop without a preceding link read");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc_pop |-> !sts.head_null)
    else $error("pop from an empty free list");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> (walk_cnt_r <= walk_last_r))
    else $error("rebuild walk ran past the last block");

  a_rebuilt_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == fbfl_pkg::ST_REBUILT)) |->
      ((out_used_r == '0) && (out_index_r == '0) && (head_r == '0)))
    else $error("rebuilt word with nonzero count or index");
`endif

endmodule

### sv/fixed_block_free_list_allocator.sv
// Allocate reads the head link in the accept cycle, then pops with busy high;
// the result word is strobed on out_valid in the cycle after the pop. Free and
// the exhausted or ignored cases end in the accept cycle, word in the next cycle.
// Rebuild does one link memory write per block of the clamped pool count after
// the start cycle. Reset is synchronous; after rst_n rises, busy stays high while
// the chain of min(256, NUM_BLOCKS) blocks is written. Results cannot be stalled.
module fixed_block_free_list_allocator #(
  parameter int NUM_BLOCKS = fbfl_pkg::NUM_BLOCKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Command channel: a word is taken when start is high and busy is low.
  input  logic                              start,
  output logic                              busy,
  input  logic [fbfl_pkg::MODE_W-1:0]       in_mode,
  input  logic [fbfl_pkg::INDEX_W-1:0]      in_free_index,
  input  logic                              in_free_is_null,
  // Result channel: each word is valid for exactly one cycle.
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [fbfl_pkg::INDEX_W-1:0]      out_block_index,
  output logic [fbfl_pkg::OFFSET_W-1:0]     out_byte_offset,
  output logic [fbfl_pkg::USED_W-1:0]       out_used_count,
  // APB-style configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fbfl_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [fbfl_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [fbfl_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  // Configuration registers. Register 0 (byte address 0) is the pool count,
  // register 1 (byte address 4) the block size. Only address bit 2 decodes
  // the register; a new pool count is used from the next rebuild on, while
  // the block size feeds the offset multiplier directly.
  logic [fbfl_pkg::POOL_W-1:0]  pool_blocks_r;
  logic [fbfl_pkg::BYTES_W-1:0] block_bytes_r;
  logic                         cfg_write;

  fbfl_pkg::cmd_t cmd;
  fbfl_pkg::sts_t sts;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_blocks_r <= fbfl_pkg::POOL_BLOCKS_RST;
      block_bytes_r <= fbfl_pkg::BLOCK_BYTES_RST;
    end else if (cfg_write) begin
      case (paddr[2])
        fbfl_pkg::REG_POOL_BLOCKS: begin
          pool_blocks_r <= pwdata[fbfl_pkg::POOL_W-1:0];
        end
        fbfl_pkg::REG_BLOCK_BYTES: begin
          block_bytes_r <= pwdata[fbfl_pkg::BYTES_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Read data is combinational from the registers; the access cycle samples it.
  always_comb begin
    case (paddr[2])
      fbfl_pkg::REG_POOL_BLOCKS: prdata = fbfl_pkg::APB_DATA_W'(pool_blocks_r);
      fbfl_pkg::REG_BLOCK_BYTES: prdata = fbfl_pkg::APB_DATA_W'(block_bytes_r);
      default:                   prdata = '0;
    endcase
  end

  // The controller sequences each command word; the datapath owns the link
  // memory, the head pointer, the use count and the result registers.
  fbfl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  fbfl_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_free_index   (in_free_index),
    .in_free_is_null (in_free_is_null),
    .pool_blocks     (pool_blocks_r),
    .block_bytes     (block_bytes_r),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_block_index (out_block_index),
    .out_byte_offset (out_byte_offset),
    .out_used_count  (out_used_count)
  );

endmodule

### tb/tb_fixed_block_free_list_allocator.sv
// Self-checking testbench for the fixed block free list allocator.
// Needs fbfl_pkg and the fixed_block_free_list_allocator top level; reads no files.
`timescale 1ns / 100ps

module tb_fixed_block_free_list_allocator;
  import fbfl_pkg::*;

  // Mode 3 has no code in the package; the block must answer it as ignored.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  // A link or head equal to the pool depth marks the end of the free list.
  localparam logic [8:0] LINK_NULL = 9'(NUM_BLOCKS_DEF);
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 35;
  // Enough allocations off a self-linked block to pin the used count at its top.
  localparam int SAT_ALLOCS  = 515;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] index;
    logic               is_null;
  } request_t;

  typedef struct packed {
    status_t             status;
    logic [INDEX_W-1:0]  index;
    logic [OFFSET_W-1:0] offset;
    logic [USED_W-1:0]   used;
  } answer_t;

  // One line of the directed script: either a register write or a command word,
  // the latter optionally carrying a hand-written expected answer.
  typedef struct packed {
    logic                  is_reg;
    logic                  reg_sel;
    logic [APB_DATA_W-1:0] reg_val;
    request_t              req;
    logic                  typed;
    answer_t               ans;
  } script_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [MODE_W-1:0]     in_mode;
  logic [INDEX_W-1:0]    in_free_index;
  logic                  in_free_is_null;
  logic                  out_valid;
  logic [1:0]            out_status;
  logic [INDEX_W-1:0]    out_block_index;
  logic [OFFSET_W-1:0]   out_byte_offset;
  logic [USED_W-1:0]     out_used_count;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fixed_block_free_list_allocator u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_free_index   (in_free_index),
    .in_free_is_null (in_free_is_null),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_block_index (out_block_index),
    .out_byte_offset (out_byte_offset),
    .out_used_count  (out_used_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Generous ceiling: far above the slowest legal run, where every word would be
  // a full-pool rebuild followed by the longest idle gap.
  initial begin
    #5_000_000;
    $display("tb_fixed_block_free_list_allocator failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the allocator: link memory, list head, used count and the two
  // configuration registers; the list state advances once per accepted command word.
  // ---------------------------------------------------------------------------
  logic [8:0]         link_mem [NUM_BLOCKS_DEF];
  logic [8:0]         head_q;
  logic [USED_W-1:0]  in_use;
  logic [POOL_W-1:0]  pool_reg;
  logic [BYTES_W-1:0] bytes_reg;

  answer_t      expected_words [$];
  logic [7:0]   held_blocks [$];
  script_row_t  script [$];

  int mismatches    = 0;
  int words_issued  = 0;
  int allocs_done   = 0;
  int exhausted_cnt = 0;
  int frees_done    = 0;
  int rebuilds_cnt  = 0;
  int reg_writes    = 0;
  int peak_used     = 0;
  bit quiet_stretch = 1'b0;

  // Chain blocks 0..n-1 in order. The pool count is clamped to 1..depth and read
  // only here, which is why a new count only matters from the next rebuild on.
  function automatic void rebuild_chain();
    int n;
    n = (pool_reg == 0) ? 1 : ((pool_reg > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(pool_reg));
    for (int i = 0; i < n - 1; i++) link_mem[i] = 9'(i + 1);
    link_mem[n - 1] = LINK_NULL;
    head_q = '0;
    in_use = '0;
  endfunction

  // Block sizes under the eight-byte minimum are rounded up; the product keeps 24 bits.
  function automatic logic [OFFSET_W-1:0] offset_for(logic [INDEX_W-1:0] idx);
    logic [31:0] sz;
    logic [31:0] prod;
    sz   = (bytes_reg < BLOCK_BYTES_MIN) ? 32'(BLOCK_BYTES_MIN) : 32'(bytes_reg);
    prod = 32'(idx) * sz;
    return prod[OFFSET_W-1:0];
  endfunction

  // Work out the answer to one command word and advance the shadow state.
  function automatic answer_t pool_answer(request_t r);
    answer_t a;
    a        = '0;
    a.status = ST_IGNORED;
    case (r.mode)
      MODE_ALLOC: begin
        if (head_q == LINK_NULL) begin
          a.status = ST_EXHAUSTED;
          exhausted_cnt++;
        end else begin
          a.index  = head_q[INDEX_W-1:0];
          head_q   = link_mem[a.index];
          if (in_use != USED_MAX) in_use++;
          a.status = ST_DONE;
          a.offset = offset_for(a.index);
          allocs_done++;
        end
      end
      MODE_FREE: begin
        // Double frees are not caught: the block is simply pushed again.
        if (!r.is_null) begin
          link_mem[r.index] = head_q;
          head_q            = {1'b0, r.index};
          if (in_use != 0) in_use--;
          a.status = ST_DONE;
          a.index  = r.index;
          a.offset = offset_for(r.index);
          frees_done++;
        end
      end
      MODE_REBUILD: begin
        rebuild_chain();
        a.status = ST_REBUILT;
        rebuilds_cnt++;
      end
      default: ;
    endcase
    a.used = in_use;
    if (int'(in_use) > peak_used) peak_used = int'(in_use);
    return a;
  endfunction

  function automatic script_row_t word_row(logic [MODE_W-1:0] mode, logic [7:0] idx,
                                           logic nul, logic typed, status_t st,
                                           logic [7:0] bi, logic [23:0] off,
                                           logic [8:0] used);
    script_row_t row;
    row         = '0;
    row.req     = '{mode, idx, nul};
    row.typed   = typed;
    row.ans     = '{st, bi, off, used};
    return row;
  endfunction

  function automatic script_row_t reg_row(logic sel, logic [APB_DATA_W-1:0] val);
    script_row_t row;
    row         = '0;
    row.is_reg  = 1'b1;
    row.reg_sel = sel;
    row.reg_val = val;
    return row;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one; every so often
  // a stretch of words is sent with no gaps at all.
  function automatic int idle_cycles();
    int r;
    if (quiet_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver. Start stays high until the block takes the word (busy low at
  // the edge). The expectation is queued at that edge, before its result can
  // appear. Fields go random while start is low so stale values prove nothing.
  // ---------------------------------------------------------------------------
  task automatic issue_word(input request_t r, input logic typed, input answer_t typed_ans,
                            output answer_t got);
    int gap;
    start           <= 1'b1;
    in_mode         <= r.mode;
    in_free_index   <= r.index;
    in_free_is_null <= r.is_null;
    do @(posedge clk); while (busy !== 1'b0);
    got = pool_answer(r);
    expected_words.push_back(typed ? typed_ans : got);
    words_issued++;
    if (words_issued % 32 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
    gap = idle_cycles();
    if (gap > 0) begin
      start           <= 1'b0;
      in_mode         <= MODE_W'($urandom);
      in_free_index   <= INDEX_W'($urandom);
      in_free_is_null <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Registers are only touched with the block idle: nothing owed and not busy.
  task automatic drain_pool_words();
    start <= 1'b0;
    while (expected_words.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // APB write followed straight by a read-back of the same register. The shadow
  // register takes the write at the edge where the access phase completes.
  task automatic set_register(input logic sel, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (sel == REG_BLOCK_BYTES) begin
      bytes_reg = value[BYTES_W-1:0];
      want      = APB_DATA_W'(bytes_reg);
    end else begin
      pool_reg = value[POOL_W-1:0];
      want     = APB_DATA_W'(pool_reg);
    end
    reg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want) begin
      $error("prdata: expected %0h, got %0h", want, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker. Results cannot be held off, so every strobed word is taken
  // at the edge that ends its cycle and matched against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    answer_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: status %0d index %0d offset %0d used %0d",
               out_status, out_block_index, out_byte_offset, out_used_count);
        mismatches++;
      end else begin
        want = expected_words.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatches++;
        end
        if (out_block_index !== want.index) begin
          $error("block_index: expected %0d, got %0d", want.index, out_block_index);
          mismatches++;
        end
        if (out_byte_offset !== want.offset) begin
          $error("byte_offset: expected %0d, got %0d", want.offset, out_byte_offset);
          mismatches++;
        end
        if (out_used_count !== want.used) begin
          $error("used_count: expected %0d, got %0d", want.used, out_used_count);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed script, then randomized phases under different register
  // settings, then a run that drives the used count into saturation.
  // ---------------------------------------------------------------------------
  initial begin
    answer_t               got;
    request_t              r;
    int                    pick;
    int                    k;
    logic [APB_DATA_W-1:0] pool_v;
    logic [APB_DATA_W-1:0] bytes_v;

    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_mode         <= MODE_ALLOC;
    in_free_index   <= '0;
    in_free_is_null <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;

    // Out of reset the pool is a full in-order chain with nothing in use.
    pool_reg  = POOL_BLOCKS_RST;
    bytes_reg = BLOCK_BYTES_RST;
    for (int i = 0; i < NUM_BLOCKS_DEF; i++) link_mem[i] = LINK_NULL;
    rebuild_chain();

    // Directed script. Rows with typed answers are the ones that follow straight
    // from the reset state or from an extreme; the rest rely on the shadow model.
    // Reset settings: 256 blocks of 64 bytes.
    script.push_back(word_row(MODE_ALLOC,   8'd0,   1'b0, 1'b1, ST_DONE,      8'd0,   24'd0,     9'd1));
    script.push_back(word_row(MODE_ALLOC,   8'd0,   1'b0, 1'b1, ST_DONE,      8'd1,   24'd64,    9'd2));
    // Freeing a block that was never handed out is accepted and pushed.
    script.push_back(word_row(MODE_FREE,    8'd255, 1'b0, 1'b1, ST_DONE,      8'd255, 24'd16320, 9'd1));
    script.push_back(word_row(MODE_ALLOC,   8'd0,   1'b0, 1'b1, ST_DONE,      8'd255, 24'd16320, 9'd2));
    script.push_back(word_row(MODE_FREE,    8'd200, 1'b1, 1'b1, ST_IGNORED,   8'd0,   24'd0,     9'd2));
    script.push_back(word_row(MODE_UNUSED,  8'd77,  1'b1, 1'b1, ST_IGNORED,   8'd0,   24'd0,     9'd2));
    script.push_back(word_row(MODE_FREE,    8'd1,   1'b0, 1'b1, ST_DONE,      8'd1,   24'd64,    9'd1));
    script.push_back(word_row(MODE_FREE,    8'd0,   1'b0, 1'b1, ST_DONE,      8'd0,   24'd0,     9'd0));
    // The used count stays at zero on a free.
    script.push_back(word_row(MODE_FREE,    8'd128, 1'b0, 1'b1, ST_DONE,      8'd128, 24'd8192,  9'd0));
    script.push_back(word_row(MODE_REBUILD, 8'd0,   1'b0, 1'b1, ST_REBUILT,   8'd0,   24'd0,     9'd0));
    // One-block pool and a zero block size, which is rounded up to eight bytes.
    script.push_back(reg_row(REG_POOL_BLOCKS, 32'd1));
    script.push_back(reg_row(REG_BLOCK_BYTES, 32'd0));
    // The new count is not in force until the rebuild.
    script.push_back(word_row(MODE_ALLOC,   8'd0,   1'b0, 1'b1, ST_DONE,      8'd0,   24'd0,     9'd1));
    script.push_back(word_row(MODE_REBUILD, 8'd0,   1'b0, 1'b1, ST_REBUILT,   8'd0,   24'd0,     9'd0));
    script.push_back(word_row(MODE_ALLOC,   8'd0,   1'b0, 1'b1, ST_DONE,      8'd0,   24'd0,     9'd1));
    script.push_back(word_row(MODE_ALLOC,   8'd0,   1'b0, 1'b1, ST_EXHAUSTED, 8'd0,   24'd0,     9'd1));
    script.push_back(word_row(MODE_FREE,    8'd3,   1'b0, 1'b1, ST_DONE,      8'd3,   24'd24,    9'd0));
    // A double free links the block to itself.
    script.push_back(word_row(MODE_FREE,    8'd3,   1'b0, 1'b1, ST_DONE,      8'd3,   24'd24,    9'd0));
    script.push_back(word_row(MODE_ALLOC,   8'd0,   1'b0, 1'b1, ST_DONE,      8'd3,   24'd24,    9'd1));
    // Largest block size: the offset product wraps at 24 bits.
    script.push_back(reg_row(REG_BLOCK_BYTES, 32'h0001_FFFF));
    script.push_back(word_row(MODE_ALLOC,   8'd0,   1'b0, 1'b0, ST_DONE,      8'd0,   24'd0,     9'd0));
    script.push_back(word_row(MODE_FREE,    8'd255, 1'b0, 1'b0, ST_DONE,      8'd0,   24'd0,     9'd0));
    // A zero pool count acts as one block.
    script.push_back(reg_row(REG_POOL_BLOCKS, 32'd0));
    script.push_back(word_row(MODE_REBUILD, 8'd0,   1'b0, 1'b1, ST_REBUILT,   8'd0,   24'd0,     9'd0));
    script.push_back(word_row(MODE_ALLOC,   8'd0,   1'b0, 1'b1, ST_DONE,      8'd0,   24'd0,     9'd1));
    script.push_back(word_row(MODE_ALLOC,   8'd0,   1'b0, 1'b1, ST_EXHAUSTED, 8'd0,   24'd0,     9'd1));
    // A count above the pool depth acts as the full depth; largest offset.
    script.push_back(reg_row(REG_POOL_BLOCKS, 32'd511));
    script.push_back(reg_row(REG_BLOCK_BYTES, 32'd65536));
    script.push_back(word_row(MODE_REBUILD, 8'd0,   1'b0, 1'b1, ST_REBUILT,   8'd0,   24'd0,     9'd0));
    script.push_back(word_row(MODE_FREE,    8'd255, 1'b0, 1'b1, ST_DONE,      8'd255, 24'hFF0000, 9'd0));
    script.push_back(word_row(MODE_ALLOC,   8'd0,   1'b0, 1'b1, ST_DONE,      8'd255, 24'hFF0000, 9'd1));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // After reset the block writes the whole chain with busy high; wait it out.
    do @(posedge clk); while (busy !== 1'b1);
    do @(posedge clk); while (busy !== 1'b0);

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        drain_pool_words();
        set_register(script[i].reg_sel, script[i].reg_val);
      end else begin
        issue_word(script[i].req, script[i].typed, script[i].ans, got);
      end
    end

    // Randomized phases. Most words are well-formed: allocations and frees of
    // blocks actually held, so small pools run dry and refill. The rest are
    // stray frees of arbitrary blocks, null frees, the unused mode and rebuilds.
    // Bits above each register's width carry junk on some writes.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin pool_v = 32'd8;   bytes_v = 32'd8;         end
        1: begin pool_v = 32'd0;   bytes_v = 32'd7;         end
        2: begin pool_v = 32'd3;   bytes_v = 32'd65536;     end
        3: begin pool_v = 32'd511; bytes_v = 32'h0001_FFFF; end
        4: begin
          pool_v  = $urandom_range(1, 32);
          bytes_v = $urandom_range(8, 65536);
        end
        default: begin
          pool_v  = 32'd256;
          bytes_v = $urandom_range(0, 131071);
        end
      endcase
      if ($urandom_range(0, 1) == 1) pool_v  = pool_v  | ($urandom & ~32'h0000_01FF);
      if ($urandom_range(0, 1) == 1) bytes_v = bytes_v | ($urandom & ~32'h0001_FFFF);
      drain_pool_words();
      set_register(REG_POOL_BLOCKS, pool_v);
      set_register(REG_BLOCK_BYTES, bytes_v);
      held_blocks.delete();

      // Usually start the phase from a fresh chain; sometimes keep the old list.
      if ($urandom_range(0, 4) != 0) begin
        r = '{MODE_REBUILD, INDEX_W'($urandom), 1'($urandom)};
        issue_word(r, 1'b0, '0, got);
      end

      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick      = $urandom_range(0, 99);
        r.index   = INDEX_W'($urandom);
        r.is_null = 1'($urandom);
        if (pick < 45) begin
          r.mode = MODE_ALLOC;
        end else if (pick < 72 && held_blocks.size() > 0) begin
          r.mode    = MODE_FREE;
          k         = $urandom_range(0, held_blocks.size() - 1);
          r.index   = held_blocks[k];
          r.is_null = 1'b0;
          held_blocks.delete(k);
        end else if (pick < 82) begin
          r.mode    = MODE_FREE;
          r.is_null = 1'b0;
        end else if (pick < 90) begin
          r.mode    = MODE_FREE;
          r.is_null = 1'b1;
        end else if (pick < 95) begin
          r.mode = MODE_UNUSED;
        end else begin
          r.mode = MODE_REBUILD;
        end
        issue_word(r, 1'b0, '0, got);
        if (r.mode == MODE_ALLOC && got.status == ST_DONE) held_blocks.push_back(got.index);
        if (r.mode == MODE_REBUILD) held_blocks.delete();
      end
    end

    // Saturation run: after a rebuild the used count is zero and block 0 is the
    // head, so freeing block 0 links it to itself and the list never runs dry.
    // Allocating past 511 shows the count holding at its ceiling.
    r = '{MODE_REBUILD, 8'd0, 1'b0};
    issue_word(r, 1'b0, '0, got);
    r = '{MODE_FREE, 8'd0, 1'b0};
    issue_word(r, 1'b0, '0, got);
    for (int n = 0; n < SAT_ALLOCS; n++) begin
      r = '{MODE_ALLOC, INDEX_W'($urandom), 1'($urandom)};
      issue_word(r, 1'b0, '0, got);
    end
    r = '{MODE_FREE, 8'd0, 1'b0};
    issue_word(r, 1'b0, '0, got);
    r = '{MODE_REBUILD, 8'd0, 1'b0};
    issue_word(r, 1'b0, '0, got);

    // Every word has exactly one result, so once nothing is owed any further
    // strobe would be a stray extra one.
    drain_pool_words();
    repeat (4) @(posedge clk);

    $display("Summary: %0d command words: %0d allocations, %0d exhausted, %0d frees, %0d rebuilds",
             words_issued, allocs_done, exhausted_cnt, frees_done, rebuilds_cnt);
    $display("Summary: %0d register writes, peak used count %0d, %0d mismatches",
             reg_writes, peak_used, mismatches);
    if (mismatches == 0) begin
      $display("tb_fixed_block_free_list_allocator passed");
    end else begin
      $display("tb_fixed_block_free_list_allocator failed");
    end
    $finish;
  end

endmodule
